// ----- rtl/core/itseg_pkg.sv -----
// itseg_pkg: shared types and constants for the interval timeline segmenter
`default_nettype none
package itseg_pkg;

  localparam int NUM_W  = 32;
  localparam int DEN_W  = 20;
  localparam int PROD_W = NUM_W + DEN_W;

  localparam logic [63:0] FNV_BASIS = 64'hcbf29ce484222325;
  localparam logic [8:0]  FNV_PRIME_LO = 9'h1b3;
  localparam int          FNV_PRIME_SHIFT = 40;

  // one event time held by a sort cell
  typedef struct packed {
    logic             vld;
    logic [NUM_W-1:0] num;
    logic [DEN_W-1:0] den;
  } ev_t;

  // per-cycle command broadcast to every sort cell
  typedef struct packed {
    logic clear;
    logic calc;
    logic ins;
    logic shift;
  } cell_ctrl_t;

  // hash unit command
  typedef struct packed {
    logic init;
    logic step;
  } fnv_ctrl_t;

endpackage
`default_nettype wire

// ----- rtl/core/itseg_cell.sv -----
// itseg_cell: one slot of the sorted event chain with its own cross-multiply compare
`default_nettype none
module itseg_cell (
  input  wire                              clk,
  input  wire                              rst_n,
  input  wire itseg_pkg::cell_ctrl_t       ctrl,
  input  wire [itseg_pkg::NUM_W-1:0]       x_num,
  input  wire [itseg_pkg::DEN_W-1:0]       x_den,
  input  wire itseg_pkg::ev_t              prev_ev,
  input  wire                              prev_lt,
  input  wire itseg_pkg::ev_t              next_ev,
  output itseg_pkg::ev_t                   ev_o,
  output logic                             lt_o,
  output logic                             eq_o
);

  itseg_pkg::ev_t                    ev_r;
  logic [itseg_pkg::PROD_W-1:0]      px_r;
  logic [itseg_pkg::PROD_W-1:0]      pv_r;

  // cross products of the incoming time against the held one
  always_ff @(posedge clk) begin
    if (ctrl.calc) begin
      px_r <= x_num * ev_r.den;
      pv_r <= ev_r.num * x_den;
    end
  end

  // an empty slot sorts after everything
  assign lt_o = !ev_r.vld || (px_r < pv_r);
  assign eq_o = ev_r.vld && (px_r == pv_r);

  // slot contents: clear, shift toward the head, or insert with shift toward the tail
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r.vld <= 1'b0;
    end else if (ctrl.clear) begin
      ev_r.vld <= 1'b0;
    end else if (ctrl.shift) begin
      ev_r <= next_ev;
    end else if (ctrl.ins && lt_o) begin
      if (prev_lt) begin
        ev_r <= prev_ev;
      end else begin
        ev_r <= '{vld: 1'b1, num: x_num, den: x_den};
      end
    end
  end

  assign ev_o = ev_r;

endmodule
`default_nettype wire

// ----- rtl/core/itseg_fnv.sv -----
// itseg_fnv: running FNV-1a 64 hash, one byte per cycle while step is high
`default_nettype none
module itseg_fnv (
  input  wire                      clk,
  input  wire                      rst_n,
  input  wire itseg_pkg::fnv_ctrl_t ctrl,
  input  wire [7:0]                byte_i,
  output logic [63:0]              hash_o
);

  logic [63:0] hash_r;
  logic [63:0] mixed;
  logic [63:0] hash_nxt;

  // multiply by the prime as a shift plus a narrow product
  assign mixed    = hash_r ^ {56'd0, byte_i};
  assign hash_nxt = (mixed << itseg_pkg::FNV_PRIME_SHIFT)
                  + 64'(mixed * itseg_pkg::FNV_PRIME_LO);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hash_r <= itseg_pkg::FNV_BASIS;
    end else if (ctrl.init) begin
      hash_r <= itseg_pkg::FNV_BASIS;
    end else if (ctrl.step) begin
      hash_r <= hash_nxt;
    end
  end

  assign hash_o = hash_r;

endmodule
`default_nettype wire

// ----- rtl/core/interval_timeline_segmenter_core.sv -----
// interval_timeline_segmenter_core: clip loader, sort chain, coverage scan and segment output
//
// Clips load at one beat per cycle while in_ready is high. The beat that carries
// in_final_clip starts the build: the 2*N+2 event times of N loaded clips (zero, the
// timeline length, each clip's start and end) enter a chain of 2*MAX_CLIPS+2 sort cells,
// each event through S_INS_CALC and then S_INS_UPD, equal times dropped on entry. Segments
// then leave from the head of the chain; for each one the block scans every loaded clip
// with a single shared cross-multiply comparator (S_CV_B1 and S_CV_B2 for the start test,
// S_CV_F1 and S_CV_F2 for the end test when the start passes) and runs the FNV hash one
// byte per cycle, eight bytes per covering clip, then waits in S_OUT for out_ready; the
// shift to the next segment happens on the output beat. in_ready is low from the final
// clip until the last segment is taken. A zero timeline length ends the run at once with
// no segments.
`default_nettype none
module interval_timeline_segmenter_core #(
  parameter int MAX_CLIPS = 16
) (
  input  wire         clk,
  input  wire         rst_n,
  // clip input
  input  wire         in_valid,
  output logic        in_ready,
  input  wire  [19:0] in_clip_start_num,
  input  wire  [9:0]  in_clip_start_den,
  input  wire  [19:0] in_clip_length_num,
  input  wire  [9:0]  in_clip_length_den,
  input  wire         in_final_clip,
  // segment output
  output logic        out_valid,
  input  wire         out_ready,
  output logic [31:0] out_seg_start_num,
  output logic [19:0] out_seg_start_den,
  output logic [31:0] out_seg_end_num,
  output logic [19:0] out_seg_end_den,
  output logic [15:0] out_covering_mask,
  output logic [63:0] out_segment_hash,
  output logic        out_clips_dropped,
  output logic        out_last_segment,
  // configuration
  input  wire         cfg_we,
  input  wire         cfg_index,
  input  wire  [19:0] cfg_wdata
);

  localparam int NEV   = 2 * MAX_CLIPS + 2;
  localparam int IDX_W = (MAX_CLIPS > 1) ? $clog2(MAX_CLIPS) : 1;
  localparam int CNT_W = $clog2(MAX_CLIPS + 1);
  localparam int INS_W = $clog2(NEV);
  localparam int NW    = itseg_pkg::NUM_W;
  localparam int DW    = itseg_pkg::DEN_W;
  localparam int PW    = itseg_pkg::PROD_W;

  localparam logic REG_LEN_NUM = 1'b0;
  localparam logic REG_LEN_DEN = 1'b1;

  typedef enum logic [3:0] {
    S_LOAD, S_INS_CALC, S_INS_UPD, S_SEG, S_CV_B1, S_CV_B2, S_CV_F1, S_CV_F2, S_HASH, S_OUT
  } state_t;

  state_t             state_r, state_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               ovf_r, ovf_nxt;
  logic [INS_W-1:0]   ins_idx_r, ins_idx_nxt;
  logic [IDX_W-1:0]   j_r, j_nxt;
  logic [2:0]         k_r, k_nxt;
  logic [15:0]        mask_r, mask_nxt;
  logic [19:0]        len_num_r;
  logic [9:0]         len_den_r;
  logic [DW-1:0]      len_den_fix;

  // clip store
  logic [19:0]        beg_num_mem [MAX_CLIPS];
  logic [9:0]         beg_den_mem [MAX_CLIPS];
  logic [NW-1:0]      fin_num_mem [MAX_CLIPS];
  logic [DW-1:0]      fin_den_mem [MAX_CLIPS];

  // current segment
  logic [NW-1:0]      seg_sn_r, seg_en_r;
  logic [DW-1:0]      seg_sd_r, seg_ed_r;
  logic               last_r;
  logic               seg_load;

  // shared comparator
  logic [PW-1:0]      cmp_a_r, cmp_b_r;
  logic               cmp_load;
  logic [NW-1:0]      mx_n, my_n;
  logic [DW-1:0]      mx_d, my_d;

  // chain
  itseg_pkg::cell_ctrl_t cc;
  itseg_pkg::ev_t     ev    [NEV];
  logic [NEV-1:0]     lt_v, eq_v;
  logic [NW-1:0]      x_num;
  logic [DW-1:0]      x_den;
  logic [IDX_W-1:0]   ins_ci;

  // hash
  itseg_pkg::fnv_ctrl_t fc;
  logic [7:0]         hash_byte;
  logic [63:0]        hash;

  // clip decode
  logic [9:0]         sd_fix, ld_fix;
  logic               accept;
  logic               ins_last, j_last, room;

  assign len_den_fix = (len_den_r == 10'd0) ? DW'(1) : DW'(len_den_r);
  assign sd_fix      = (in_clip_start_den == 10'd0) ? 10'd1 : in_clip_start_den;
  assign ld_fix      = (in_clip_length_den == 10'd0) ? 10'd1 : in_clip_length_den;
  assign in_ready    = (state_r == S_LOAD);
  assign accept      = in_valid && in_ready;
  assign room        = (32'(cnt_r) < MAX_CLIPS);
  assign ins_last    = (32'(ins_idx_r) == 2 * 32'(cnt_r) + 1);
  assign j_last      = (32'(j_r) + 1 == 32'(cnt_r));

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_num_r <= 20'd0;
      len_den_r <= 10'd1;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_LEN_NUM: len_num_r <= cfg_wdata;
        REG_LEN_DEN: len_den_r <= cfg_wdata[9:0];
        default: ;
      endcase
    end
  end

  // clip store write: start and exact end
  always_ff @(posedge clk) begin
    if (accept && room) begin
      beg_num_mem[cnt_r[IDX_W-1:0]] <= in_clip_start_num;
      beg_den_mem[cnt_r[IDX_W-1:0]] <= sd_fix;
      fin_num_mem[cnt_r[IDX_W-1:0]] <= NW'(in_clip_start_num * ld_fix)
                                     + NW'(in_clip_length_num * sd_fix);
      fin_den_mem[cnt_r[IDX_W-1:0]] <= DW'(sd_fix * ld_fix);
    end
  end

  // event source for insertion: zero, timeline length, then clip start and end pairs
  assign ins_ci = IDX_W'((32'(ins_idx_r) - 32'd2) >> 1);
  always_comb begin
    if (ins_idx_r == INS_W'(0)) begin
      x_num = '0;
      x_den = DW'(1);
    end else if (ins_idx_r == INS_W'(1)) begin
      x_num = NW'(len_num_r);
      x_den = len_den_fix;
    end else if (!ins_idx_r[0]) begin
      x_num = NW'(beg_num_mem[ins_ci]);
      x_den = DW'(beg_den_mem[ins_ci]);
    end else begin
      x_num = fin_num_mem[ins_ci];
      x_den = fin_den_mem[ins_ci];
    end
  end

  // sort chain
  for (genvar g = 0; g < NEV; g++) begin : g_cell
    itseg_pkg::ev_t prev_ev, next_ev;
    logic           prev_lt;
    if (g == 0) begin : g_head
      assign prev_ev = '0;
      assign prev_lt = 1'b0;
    end else begin : g_mid
      assign prev_ev = ev[g-1];
      assign prev_lt = lt_v[g-1];
    end
    if (g == NEV - 1) begin : g_tail
      assign next_ev = '0;
    end else begin : g_body
      assign next_ev = ev[g+1];
    end
    itseg_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (cc),
      .x_num   (x_num),
      .x_den   (x_den),
      .prev_ev (prev_ev),
      .prev_lt (prev_lt),
      .next_ev (next_ev),
      .ev_o    (ev[g]),
      .lt_o    (lt_v[g]),
      .eq_o    (eq_v[g])
    );
  end

  // comparator operands: start test, then end test
  always_comb begin
    if (state_r == S_CV_B1) begin
      mx_n = seg_sn_r;
      mx_d = DW'(beg_den_mem[j_r]);
      my_n = NW'(beg_num_mem[j_r]);
      my_d = seg_sd_r;
    end else begin
      mx_n = fin_num_mem[j_r];
      mx_d = seg_ed_r;
      my_n = seg_en_r;
      my_d = fin_den_mem[j_r];
    end
  end

  always_ff @(posedge clk) begin
    if (cmp_load) begin
      cmp_a_r <= mx_n * mx_d;
      cmp_b_r <= my_n * my_d;
    end
  end

  // segment latch from the head of the chain
  always_ff @(posedge clk) begin
    if (seg_load) begin
      seg_sn_r <= ev[0].num;
      seg_sd_r <= ev[0].den;
      seg_en_r <= ev[1].num;
      seg_ed_r <= ev[1].den;
      last_r   <= (ev[1].num == NW'(len_num_r)) && (ev[1].den == len_den_fix);
    end
  end

  // hash unit
  assign hash_byte = (k_r == 3'd0) ? 8'(j_r) : 8'd0;
  itseg_fnv u_fnv (
    .clk    (clk),
    .rst_n  (rst_n),
    .ctrl   (fc),
    .byte_i (hash_byte),
    .hash_o (hash)
  );

  // control sequencer
  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    ovf_nxt     = ovf_r;
    ins_idx_nxt = ins_idx_r;
    j_nxt       = j_r;
    k_nxt       = k_r;
    mask_nxt    = mask_r;
    cc          = '0;
    fc          = '0;
    seg_load    = 1'b0;
    cmp_load    = 1'b0;
    unique case (state_r)
      S_LOAD: begin
        if (accept) begin
          if (room) begin
            cnt_nxt = cnt_r + CNT_W'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          if (in_final_clip) begin
            if (len_num_r == 20'd0) begin
              cnt_nxt = '0;
              ovf_nxt = 1'b0;
            end else begin
              cc.clear    = 1'b1;
              ins_idx_nxt = '0;
              state_nxt   = S_INS_CALC;
            end
          end
        end
      end
      S_INS_CALC: begin
        cc.calc   = 1'b1;
        state_nxt = S_INS_UPD;
      end
      S_INS_UPD: begin
        cc.ins = !(|eq_v);
        if (ins_last) begin
          state_nxt = S_SEG;
        end else begin
          ins_idx_nxt = ins_idx_r + INS_W'(1);
          state_nxt   = S_INS_CALC;
        end
      end
      S_SEG: begin
        seg_load  = 1'b1;
        fc.init   = 1'b1;
        j_nxt     = '0;
        mask_nxt  = '0;
        state_nxt = S_CV_B1;
      end
      S_CV_B1, S_CV_F1: begin
        cmp_load  = 1'b1;
        state_nxt = (state_r == S_CV_B1) ? S_CV_B2 : S_CV_F2;
      end
      S_CV_B2, S_CV_F2, S_HASH: begin
        if (state_r == S_CV_B2 && cmp_a_r >= cmp_b_r) begin
          state_nxt = S_CV_F1;
        end else if (state_r == S_CV_F2 && cmp_a_r >= cmp_b_r) begin
          for (int m = 0; m < 16; m++) begin
            if (32'(j_r) == m) mask_nxt[m] = 1'b1;
          end
          k_nxt     = '0;
          state_nxt = S_HASH;
        end else if (state_r == S_HASH && k_r != 3'd7) begin
          fc.step = 1'b1;
          k_nxt   = k_r + 3'd1;
        end else begin
          // move on to the next clip or finish the segment
          fc.step = (state_r == S_HASH);
          if (j_last) begin
            state_nxt = S_OUT;
          end else begin
            j_nxt     = j_r + IDX_W'(1);
            state_nxt = S_CV_B1;
          end
        end
      end
      S_OUT: begin
        if (out_ready) begin
          if (last_r) begin
            cnt_nxt   = '0;
            ovf_nxt   = 1'b0;
            state_nxt = S_LOAD;
          end else begin
            cc.shift  = 1'b1;
            state_nxt = S_SEG;
          end
        end
      end
      default: state_nxt = S_LOAD;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_LOAD;
      cnt_r     <= '0;
      ovf_r     <= 1'b0;
      ins_idx_r <= '0;
      j_r       <= '0;
      k_r       <= '0;
      mask_r    <= '0;
    end else begin
      state_r   <= state_nxt;
      cnt_r     <= cnt_nxt;
      ovf_r     <= ovf_nxt;
      ins_idx_r <= ins_idx_nxt;
      j_r       <= j_nxt;
      k_r       <= k_nxt;
      mask_r    <= mask_nxt;
    end
  end

  // result beat
  assign out_valid         = (state_r == S_OUT);
  assign out_seg_start_num = seg_sn_r;
  assign out_seg_start_den = seg_sd_r;
  assign out_seg_end_num   = seg_en_r;
  assign out_seg_end_den   = seg_ed_r;
  assign out_covering_mask = mask_r;
  assign out_segment_hash  = hash;
  assign out_clips_dropped = ovf_r;
  assign out_last_segment  = last_r;

endmodule
`default_nettype wire
